// ----- design/kda_pkg.sv -----
// Package with shared constants and types for the key debounce and autorepeat block.
`default_nettype none
package kda_pkg;

  // Default parameter values.
  localparam int KEY_COUNT_DEF = 8;
  localparam int TIME_BITS_DEF = 32;

  // Divider operand widths (delay by acceleration divisor) and debounce delay width.
  localparam int DLY_W = 16;
  localparam int ACC_W = 8;
  localparam int DBN_W = 8;

  // Register reset values.
  localparam logic [DLY_W-1:0] NORMAL_DELAY_RST   = 16'd500;
  localparam logic [ACC_W-1:0] REPEAT_ACCEL_RST   = 8'd4;
  localparam logic [DLY_W-1:0] DLY_FLOOR_RST      = 16'd20;
  localparam logic [DBN_W-1:0] DEBOUNCE_DELAY_RST = 8'd10;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_NORMAL_DELAY   = 2'd0;
  localparam logic [1:0] REG_REPEAT_ACCEL   = 2'd1;
  localparam logic [1:0] REG_DLY_FLOOR      = 2'd2;
  localparam logic [1:0] REG_DEBOUNCE_DELAY = 2'd3;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// ----- design/kda_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module kda_div #(
  parameter int DIVIDEND_W = kda_pkg::DLY_W,
  parameter int DIVISOR_W  = kda_pkg::ACC_W
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  input  wire  [DIVIDEND_W-1:0]       dividend,
  input  wire  [DIVISOR_W-1:0]        divisor,
  output logic [DIVIDEND_W-1:0]       quotient,
  output kda_pkg::div_stat_t          stat
);
  import kda_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dvs_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  done_r;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;
  logic [DIVISOR_W:0]    diff_nxt;

  // The partial remainder stays below the divisor, so the shifted trial
  // value needs only one extra bit.
  assign trial    = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits     = (trial >= {1'b0, dvs_r});
  assign diff_nxt = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r <= dividend;
        rem_r <= '0;
        dvs_r <= divisor;
        cnt_r <= CNT_W'(DIVIDEND_W);
      end else if (cnt_r != '0) begin
        quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
        rem_r <= fits ? diff_nxt[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo_r;
  // Busy in the upper bit, done in the lower bit.
  assign stat     = {(cnt_r != '0), done_r};

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done lasted more than one cycle");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CNT_W'(1)) |=> done_r)
    else $error("divider finished without done");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (cnt_r == '0))
    else $error("divider started while busy");

endmodule
`default_nettype wire

// ----- design/key_debounce_autorepeat_accel.sv -----
// Top level of the key debounce, autorepeat and repeat acceleration block.
//
// Usage: each poll item on the in_ stream carries a millisecond time, the raw
// key levels and the mask of keys allowed to autorepeat. Every accepted item
// produces exactly one result item on the out_ stream holding the keys to
// report on that poll (zero for a poll before the debounce deadline or with an
// unsettled sample).
// Flow: a poll that needs no repeat delay update passes from acceptance
// through the EVAL and OUT states. A repeat event shortens the delay through a
// bit-serial divider of the 16-bit delay by the acceleration divisor, one
// quotient bit per cycle, waiting in DIV, then passes CLAMP and RDL before OUT.
// One item is in work at a time; a new poll is accepted only after the last
// has left OUT and the block is back in IDLE.
// Reset (rst_n, synchronous, active low) restores the configuration registers
// to their defaults and resets the scan state; no clearing pass is needed.
// Stalls: the result sits in an output register. A new poll is accepted while
// it waits; the sequencer only holds before writing the next result until the
// receiver has taken the previous one.
// The APB-style port writes the four registers at byte addresses 0, 4, 8, 12;
// write only while the block is idle.
`default_nettype none
module key_debounce_autorepeat_accel #(
  parameter int KEY_COUNT = kda_pkg::KEY_COUNT_DEF,
  parameter int TIME_BITS = kda_pkg::TIME_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  // Poll items: [31:0] now_ms, [39:32] raw_keys, [47:40] repeat_mask.
  input  wire  [47:0] in_tdata,
  input  wire         in_tvalid,
  output logic        in_tready,
  // Result items: [7:0] pressed_keys.
  output logic [7:0]  out_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // Configuration port.
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [3:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import kda_pkg::*;

  // Only the keys that fit the 8-bit fields are tracked.
  localparam int KW = (KEY_COUNT < 8) ? KEY_COUNT : 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_CLAMP,
    ST_RDL,
    ST_OUT
  } state_t;

  state_t                state_r;

  // Configuration registers.
  logic [DLY_W-1:0]      normal_delay_r;
  logic [ACC_W-1:0]      repeat_accel_r;
  logic [DLY_W-1:0]      dly_floor_r;
  logic [DBN_W-1:0]      debounce_delay_r;

  // Scan state.
  logic [TIME_BITS-1:0]  debounce_deadline_r;
  logic [TIME_BITS-1:0]  repeat_deadline_r;
  logic [KW-1:0]         previous_sample_r;
  logic [KW-1:0]         last_stable_r;
  logic [KW-1:0]         repeating_r;
  logic [DLY_W-1:0]      current_delay_r;

  // Captured poll and the report being built.
  logic [TIME_BITS-1:0]  now_r;
  logic [KW-1:0]         sample_r;
  logic [KW-1:0]         rmask_r;
  logic [KW-1:0]         report_r;

  // Output register.
  logic                  out_valid_r;
  logic [KW-1:0]         out_data_r;

  logic                  cfg_wr;
  logic [1:0]            cfg_idx;
  logic [DLY_W-1:0]      wr_dly;
  logic [ACC_W-1:0]      wr_acc;
  logic [KW-1:0]         held;
  logic [KW-1:0]         fresh;
  logic                  div_start;
  logic [DLY_W-1:0]      quotient;
  div_stat_t             div_stat;
  logic [DLY_W-1:0]      shrunk_nxt;
  logic                  in_acc;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];
  assign wr_dly     = cfg_pwdata[DLY_W-1:0];
  assign wr_acc     = cfg_pwdata[ACC_W-1:0];

  always_comb begin
    unique case (cfg_idx)
      REG_NORMAL_DELAY:   cfg_prdata = 32'(normal_delay_r);
      REG_REPEAT_ACCEL:   cfg_prdata = 32'(repeat_accel_r);
      REG_DLY_FLOOR:      cfg_prdata = 32'(dly_floor_r);
      REG_DEBOUNCE_DELAY: cfg_prdata = 32'(debounce_delay_r);
      default:            cfg_prdata = '0;
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;

  // Keys held that were already repeating, and keys newly pressed.
  assign held  = sample_r & repeating_r;
  assign fresh = sample_r & ~last_stable_r;

  // A repeat is due when a held key repeats and the repeat deadline passed;
  // only then is the divider started.
  assign div_start = (state_r == ST_EVAL) && (now_r >= debounce_deadline_r) &&
                     (sample_r == previous_sample_r) && (held != '0) &&
                     (now_r > repeat_deadline_r);

  // The quotient never exceeds the dividend, so the subtraction cannot wrap.
  assign shrunk_nxt = current_delay_r - quotient;

  kda_div #(
    .DIVIDEND_W (DLY_W),
    .DIVISOR_W  (ACC_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (current_delay_r),
    .divisor  (repeat_accel_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r             <= ST_IDLE;
      normal_delay_r      <= NORMAL_DELAY_RST;
      repeat_accel_r      <= REPEAT_ACCEL_RST;
      dly_floor_r         <= DLY_FLOOR_RST;
      debounce_delay_r    <= DEBOUNCE_DELAY_RST;
      debounce_deadline_r <= '0;
      repeat_deadline_r   <= '0;
      previous_sample_r   <= '0;
      last_stable_r       <= '0;
      repeating_r         <= '0;
      current_delay_r     <= NORMAL_DELAY_RST;
      out_valid_r         <= 1'b0;
    end else begin
      // Register writes, clamped to their legal ranges.
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_NORMAL_DELAY:
            normal_delay_r <= (wr_dly < dly_floor_r) ? dly_floor_r : wr_dly;
          REG_REPEAT_ACCEL:
            repeat_accel_r <= (wr_acc == '0) ? ACC_W'(1) : wr_acc;
          REG_DLY_FLOOR:
            dly_floor_r <= (wr_dly == '0) ? DLY_W'(1) : wr_dly;
          REG_DEBOUNCE_DELAY:
            debounce_delay_r <= cfg_pwdata[DBN_W-1:0];
          default: ;
        endcase
      end

      // The output register loads a new result when it is free or being
      // emptied in this cycle, and otherwise drops valid once taken.
      if ((state_r == ST_OUT) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            now_r    <= TIME_BITS'(in_tdata[31:0]);
            sample_r <= in_tdata[32 +: KW];
            rmask_r  <= in_tdata[40 +: KW];
            state_r  <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (now_r < debounce_deadline_r) begin
            report_r <= '0;
            state_r  <= ST_OUT;
          end else begin
            debounce_deadline_r <= now_r + TIME_BITS'(debounce_delay_r);
            if (sample_r != previous_sample_r) begin
              previous_sample_r <= sample_r;
              report_r          <= '0;
              state_r           <= ST_OUT;
            end else if (held != '0) begin
              if (now_r > repeat_deadline_r) begin
                report_r <= fresh | held;
                state_r  <= ST_DIV;
              end else begin
                report_r      <= fresh;
                last_stable_r <= sample_r;
                state_r       <= ST_OUT;
              end
            end else begin
              // No repeating key held: restart at the normal delay.
              report_r          <= fresh;
              repeating_r       <= sample_r & rmask_r;
              current_delay_r   <= normal_delay_r;
              repeat_deadline_r <= now_r + TIME_BITS'(normal_delay_r);
              last_stable_r     <= sample_r;
              state_r           <= ST_OUT;
            end
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state_r <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          current_delay_r <= (shrunk_nxt < dly_floor_r) ? dly_floor_r : shrunk_nxt;
          repeating_r     <= sample_r & rmask_r;
          last_stable_r   <= sample_r;
          state_r         <= ST_RDL;
        end
        ST_RDL: begin
          repeat_deadline_r <= now_r + TIME_BITS'(current_delay_r);
          state_r           <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r <= report_r;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 8'(out_data_r);

  a_accel_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (repeat_accel_r != '0) && (dly_floor_r != '0))
    else $error("divisor or delay floor reached zero");

  a_div_to_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_stat.done) |=> (state_r == ST_CLAMP))
    else $error("divider result not taken");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_stat.busy)
    else $error("poll accepted while divider busy");

  a_repeat_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLAMP) |=> (current_delay_r >= dly_floor_r))
    else $error("repeat delay fell below the floor");

endmodule
`default_nettype wire

// ----- sim/key_debounce_autorepeat_accel_tb.sv -----
// Self-checking testbench for the key debounce, autorepeat and acceleration block.
module key_debounce_autorepeat_accel_tb;
  import kda_pkg::*;

  // The receiver's long hold-off, the no-progress limit and the tail after the last result.
  localparam int STALL_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 30;

  // One poll as it travels on in_tdata, with now_ms in the lowest bits.
  typedef struct packed {
    logic [7:0]  repeat_mask;
    logic [7:0]  raw_keys;
    logic [31:0] now_ms;
  } poll_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic [47:0] in_tdata    = '0;  // [31:0] now_ms, [39:32] raw_keys, [47:40] repeat_mask
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  out_tdata;         // [7:0] pressed_keys
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  key_debounce_autorepeat_accel dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Our own copy of the registers, already clamped the way the block clamps them.
  logic [15:0] nrm_dly = NORMAL_DELAY_RST;
  logic [7:0]  acc_div = REPEAT_ACCEL_RST;
  logic [15:0] min_dly = DLY_FLOOR_RST;
  logic [7:0]  dbn_dly = DEBOUNCE_DELAY_RST;

  // Our own copy of the scan state.
  logic [31:0] dbn_deadline = '0;
  logic [31:0] rpt_deadline = '0;
  logic [7:0]  prev_sample  = '0;
  logic [7:0]  stable_keys  = '0;
  logic [7:0]  rpt_keys     = '0;
  logic [15:0] cur_delay    = NORMAL_DELAY_RST;

  // Polls waiting to be offered, and the key reports still owed by the block.
  poll_t      poll_q[$];
  logic [7:0] report_q[$];

  int errors     = 0;
  int idle_pct   = 0;  // chance per cycle that either side starts an idle burst
  int stall_ask  = 0;  // bumped by the stimulus to ask the receiver for a long hold-off

  // Random stimulus keeps a running clock and a key pattern that is held
  // over several polls, since only a repeated sample gets past debouncing.
  logic [31:0] clock_ms  = '0;
  logic [7:0]  hold_keys = '0;
  logic [7:0]  hold_mask = 8'hFF;

  // Works out the keys reported for one accepted poll and advances the state.
  function automatic logic [7:0] scan_poll(input poll_t p);
    logic [7:0]  report;
    logic [7:0]  held;
    logic [15:0] shorter;
    // A poll ahead of the debounce deadline is dropped without touching any state.
    if (p.now_ms < dbn_deadline) return 8'h00;
    dbn_deadline = p.now_ms + {24'd0, dbn_dly};
    // A sample that has not settled is only remembered.
    if (p.raw_keys != prev_sample) begin
      prev_sample = p.raw_keys;
      return 8'h00;
    end
    report = p.raw_keys & ~stable_keys;
    held   = p.raw_keys & rpt_keys;
    if (held != 8'h00) begin
      // Keys still held from the repeat set fire again once the deadline has
      // passed; each repeat cuts the delay by delay/accel, down to the floor.
      if (p.now_ms > rpt_deadline) begin
        report       = report | held;
        rpt_keys     = p.raw_keys & p.repeat_mask;
        shorter      = cur_delay - cur_delay / acc_div;
        cur_delay    = (shorter < min_dly) ? min_dly : shorter;
        rpt_deadline = p.now_ms + {16'd0, cur_delay};
      end
    end else begin
      // Nothing held from the repeat set: reload the set and restart at the normal delay.
      rpt_keys     = p.raw_keys & p.repeat_mask;
      cur_delay    = nrm_dly;
      rpt_deadline = p.now_ms + {16'd0, cur_delay};
    end
    stable_keys = p.raw_keys;
    return report;
  endfunction

  // Sender. It holds an offered poll until it is taken, and otherwise may
  // drop valid for a random idle burst.
  poll_t tx_item;
  int    tx_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) report_q.push_back(scan_poll(tx_item));
      if (in_tvalid && !in_tready) begin
        // The block is busy; keep offering the same item.
      end else if (tx_gap > 0) begin
        tx_gap    <= tx_gap - 1;
        in_tvalid <= 1'b0;
      end else if (poll_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        tx_item = poll_q.pop_front();
        in_tdata  <= tx_item;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
        if (poll_q.size() > 0) tx_gap <= $urandom_range(3, 0);
      end
    end
  end

  // Receiver. Checks every accepted result against the oldest owed report,
  // and throttles ready with short bursts or a long hold-off on request.
  int         rx_gap     = 0;
  int         rx_hold    = 0;
  int         stall_done = 0;
  logic [7:0] want;

  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      if (report_q.size() == 0) begin
        $display("%0t: pressed_keys expected none, got %02h", $time, out_tdata);
        errors++;
      end else begin
        want = report_q.pop_front();
        if (out_tdata !== want) begin
          $display("%0t: pressed_keys expected %02h, got %02h", $time, want, out_tdata);
          errors++;
        end
      end
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold    <= rx_hold - 1;
      out_tready <= 1'b0;
    end else if (stall_done != stall_ask) begin
      stall_done <= stall_ask;
      rx_hold    <= STALL_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap     <= rx_gap - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(99) < idle_pct) begin
      rx_gap     <= $urandom_range(3, 0);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: while work is outstanding, some item must move on either side
  // within the limit.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (!in_tvalid && poll_q.size() == 0 && report_q.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("key_debounce_autorepeat_accel: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_poll(input logic [31:0] t_ms, input logic [7:0] keys,
                           input logic [7:0] rmask);
    poll_q.push_back(poll_t'({rmask, keys, t_ms}));
  endtask

  // Waits, sampling at falling edges, until every poll is taken and every report is back.
  task automatic drain();
    @(negedge clk);
    while (in_tvalid || poll_q.size() != 0 || report_q.size() != 0) @(negedge clk);
  endtask

  // One register write: setup cycle, then access cycle until pready. The
  // local copy is clamped the same way as the block clamps it.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_NORMAL_DELAY:   nrm_dly = (value[15:0] < min_dly) ? min_dly : value[15:0];
      REG_REPEAT_ACCEL:   acc_div = (value[7:0] == 8'd0) ? 8'd1 : value[7:0];
      REG_DLY_FLOOR:      min_dly = (value[15:0] == 16'd0) ? 16'd1 : value[15:0];
      REG_DEBOUNCE_DELAY: dbn_dly = value[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Random polls. Most steps land just past the debounce deadline, some come
  // early, some skip far ahead so the repeat deadline passes. Key patterns
  // are held for several polls, with the odd one-poll glitch and random mask.
  task automatic add_polls(input int n);
    int         pick;
    logic [7:0] keys;
    logic [7:0] rmask;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 10)      clock_ms += $urandom_range((dbn_dly > 0) ? int'(dbn_dly) - 1 : 0);
      else if (pick < 80) clock_ms += int'(dbn_dly) + $urandom_range(3);
      else if (pick < 95) clock_ms += $urandom_range(120);
      else                clock_ms += $urandom_range(70000);
      pick = $urandom_range(99);
      if (pick < 8) begin
        hold_keys = ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom);
        hold_mask = ($urandom_range(2) == 0) ? 8'hFF : 8'($urandom);
      end
      keys  = (pick >= 8 && pick < 13) ? 8'($urandom) : hold_keys;
      rmask = (pick >= 95) ? 8'($urandom) : hold_mask;
      push_poll(clock_ms, keys, rmask);
    end
  endtask

  initial begin
    idle_pct = 20;

    // Directed polls under the reset settings (debounce 10, normal 500,
    // divisor 4, floor 20). A settled all-zero sample arms the repeat state,
    // then an early poll, an unsettled sample and a fresh press.
    push_poll(32'd0,    8'h00, 8'h00);
    push_poll(32'd5,    8'hFF, 8'hFF);
    push_poll(32'd10,   8'hFF, 8'hFF);
    push_poll(32'd20,   8'hFF, 8'hFF);
    // Held keys: nothing before the repeat deadline, then accelerating repeats,
    // the last ones narrowing the repeat set through the mask.
    push_poll(32'd30,   8'hFF, 8'hFF);
    push_poll(32'd600,  8'hFF, 8'hFF);
    push_poll(32'd1000, 8'hFF, 8'h0F);
    push_poll(32'd1300, 8'hFF, 8'h0F);
    // A change to keys outside the repeat set reloads the normal delay.
    push_poll(32'd1310, 8'hF0, 8'h0F);
    push_poll(32'd1320, 8'hF0, 8'h0F);
    // Full release, a single key without repeat, then alternating patterns.
    push_poll(32'd1330, 8'h00, 8'h00);
    push_poll(32'd1340, 8'h00, 8'h00);
    push_poll(32'd1350, 8'h01, 8'h00);
    push_poll(32'd1360, 8'h01, 8'h00);
    push_poll(32'd1370, 8'hAA, 8'h55);
    push_poll(32'd1380, 8'hAA, 8'h55);
    push_poll(32'd1390, 8'h55, 8'hAA);
    push_poll(32'd1400, 8'h55, 8'hAA);
    // Top of the time range: the deadline sum wraps to a small value and the
    // plain unsigned compare then lets the low times through again.
    push_poll(32'hFFFF_FFF0, 8'h55, 8'hAA);
    push_poll(32'hFFFF_FFF5, 8'h55, 8'hAA);
    push_poll(32'hFFFF_FFFF, 8'h55, 8'hAA);
    push_poll(32'd9,    8'h55, 8'hAA);
    push_poll(32'd19,   8'h55, 8'hAA);
    clock_ms = 32'd19;
    hold_keys = 8'h55;
    hold_mask = 8'hAA;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Short delays so repeats and acceleration come often. Halfway the
    // sender stops until every report is back.
    drain();
    idle_pct = 30;
    reg_write(REG_DLY_FLOOR,      32'd5);
    reg_write(REG_NORMAL_DELAY,   32'd40);
    reg_write(REG_REPEAT_ACCEL,   32'd2);
    reg_write(REG_DEBOUNCE_DELAY, 32'd3);
    add_polls(120);
    drain();
    add_polls(130);

    // Low extremes: zero debounce, divisor written as zero (clamped to one),
    // normal delay raised to the floor in force, floor written as zero.
    drain();
    idle_pct = 0;
    reg_write(REG_REPEAT_ACCEL,   32'd0);
    reg_write(REG_DEBOUNCE_DELAY, 32'd0);
    reg_write(REG_NORMAL_DELAY,   32'd1);
    reg_write(REG_DLY_FLOOR,      32'd0);
    add_polls(200);

    // High extremes: largest floor, normal delay clamped up to it, largest
    // divisor and debounce.
    drain();
    idle_pct = 40;
    reg_write(REG_DLY_FLOOR,      32'd65535);
    reg_write(REG_NORMAL_DELAY,   32'd0);
    reg_write(REG_REPEAT_ACCEL,   32'd255);
    reg_write(REG_DEBOUNCE_DELAY, 32'd255);
    add_polls(150);

    // A later, lower floor leaves the already clamped normal delay alone.
    drain();
    idle_pct = 25;
    reg_write(REG_DLY_FLOOR,      32'd100);
    reg_write(REG_NORMAL_DELAY,   32'd50);
    reg_write(REG_DLY_FLOOR,      32'd10);
    reg_write(REG_REPEAT_ACCEL,   32'd3);
    reg_write(REG_DEBOUNCE_DELAY, 32'd5);
    add_polls(250);

    // Upper write bits are ignored. This phase opens with a long receiver
    // hold-off while the sender keeps offering, so the block backs up.
    drain();
    idle_pct = 30;
    reg_write(REG_NORMAL_DELAY,   32'hFFFF_0030);
    reg_write(REG_REPEAT_ACCEL,   32'hFFFF_FF08);
    reg_write(REG_DEBOUNCE_DELAY, 32'd1);
    stall_ask = stall_ask + 1;
    add_polls(250);

    // Final stretch at full rate on both sides.
    drain();
    idle_pct = 0;
    reg_write(REG_NORMAL_DELAY,   32'd25);
    reg_write(REG_REPEAT_ACCEL,   32'd2);
    reg_write(REG_DLY_FLOOR,      32'd3);
    reg_write(REG_DEBOUNCE_DELAY, 32'd2);
    add_polls(250);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("key_debounce_autorepeat_accel: match");
    end else begin
      $display("key_debounce_autorepeat_accel: mismatch");
    end
    $finish;
  end

endmodule

// ----- key_debounce_autorepeat_accel.f -----
design/kda_pkg.sv
design/kda_div.sv
design/key_debounce_autorepeat_accel.sv
sim/key_debounce_autorepeat_accel_tb.sv
